>>> design/ppbb_pkg.sv
// Package for the projected point bounding box block.
// Holds the field widths, register indexes, divider sizing and the
// command and status structs shared by the controller and the datapath.
package ppbb_pkg;

	localparam int IN_W      = 16;
	localparam int FOCAL_W   = 12;
	localparam int MAG_W     = 28;
	localparam int DIV_STEPS = MAG_W / 2;
	localparam int CNT_W     = 4;
	localparam int SUM_W     = 34;
	localparam int ADDR_W    = 4;
	localparam int PDATA_W   = 32;

	localparam logic [1:0] REG_FOCAL = 2'd0;
	localparam logic [1:0] REG_CCOL  = 2'd1;
	localparam logic [1:0] REG_CROW  = 2'd2;

	localparam logic [FOCAL_W-1:0] FOCAL_RST = 12'd525;
	localparam logic [FOCAL_W-1:0] CCOL_RST  = 12'd320;
	localparam logic [FOCAL_W-1:0] CROW_RST  = 12'd240;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_start;
		logic div_row;
		logic fin_col;
		logic fin_row;
		logic update;
	} ppbb_cmd_t;

	typedef struct packed {
		logic div_done;
		logic last;
	} ppbb_stat_t;

endpackage

>>> design/ppbb_divider.sv
// Serial restoring divider, two quotient bits per cycle.
// Depends on ppbb_pkg for the dividend and divisor widths.
module ppbb_divider import ppbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [IN_W-1:0]  divisor,
	output logic             done,
	output logic [MAG_W-1:0] quotient
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IN_W-1:0]  rem_q;
	logic [IN_W-1:0]  dvs_q;
	logic [MAG_W-1:0] quo_q;

	logic [IN_W:0]   t1, t2;
	logic            ge1, ge2;
	logic [IN_W-1:0] r1, r2;

	always_comb begin
		t1  = {rem_q, quo_q[MAG_W-1]};
		ge1 = t1 >= {1'b0, dvs_q};
		r1  = ge1 ? IN_W'(t1 - {1'b0, dvs_q}) : t1[IN_W-1:0];
		t2  = {r1, quo_q[MAG_W-2]};
		ge2 = t2 >= {1'b0, dvs_q};
		r2  = ge2 ? IN_W'(t2 - {1'b0, dvs_q}) : t2[IN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[MAG_W-3:0], ge1, ge2};
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

>>> design/ppbb_datapath.sv
// Datapath: input capture, magnitude multiply, shared divider, sign and
// center correction with clamping, running box and result registers.
// Depends on ppbb_pkg and ppbb_divider.
module ppbb_datapath import ppbb_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppbb_cmd_t                    cmd,
	output ppbb_stat_t                   stat,
	input  logic signed [IN_W-1:0]       point_x,
	input  logic signed [IN_W-1:0]       point_y,
	input  logic [IN_W-1:0]              point_z,
	input  logic                         last_point,
	input  logic [FOCAL_W-1:0]           focal_length,
	input  logic [FOCAL_W-1:0]           center_column,
	input  logic [FOCAL_W-1:0]           center_row,
	output logic signed [COORD_BITS-1:0] min_column,
	output logic signed [COORD_BITS-1:0] max_column,
	output logic signed [COORD_BITS-1:0] min_row,
	output logic signed [COORD_BITS-1:0] max_row
);

	localparam logic signed [SUM_W-1:0] CLAMP_HI =
		SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] CLAMP_LO = ~CLAMP_HI;

	logic signed [IN_W-1:0]       x_q, y_q;
	logic [IN_W-1:0]              z_q;
	logic                         last_q;
	logic [MAG_W-1:0]             mag_c_q, mag_r_q;
	logic                         neg_c_q, neg_r_q;
	logic signed [COORD_BITS-1:0] col_q, row_q;
	logic signed [COORD_BITS-1:0] lo_col_q, hi_col_q, lo_row_q, hi_row_q;
	logic                         started_q;

	logic [IN_W-1:0]              abs_x, abs_y;
	logic [MAG_W-1:0]             div_quo;
	logic                         div_done;
	logic                         fin_neg;
	logic [SUM_W-1:0]             q_ext, q_signed;
	logic signed [SUM_W-1:0]      sum, clamped;
	logic signed [COORD_BITS-1:0] proj;
	logic signed [COORD_BITS-1:0] nx_lo_col, nx_hi_col, nx_lo_row, nx_hi_row;

	assign abs_x = x_q[IN_W-1] ? (~x_q + 1'b1) : x_q;
	assign abs_y = y_q[IN_W-1] ? (~y_q + 1'b1) : y_q;

	ppbb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_row ? mag_r_q : mag_c_q),
		.divisor  (z_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Truncation toward zero: divide magnitudes, then restore the sign.
	always_comb begin
		fin_neg  = cmd.fin_row ? neg_r_q : neg_c_q;
		q_ext    = SUM_W'(div_quo);
		q_signed = fin_neg ? (~q_ext + 1'b1) : q_ext;
		sum      = $signed(q_signed + SUM_W'(cmd.fin_row ? center_row : center_column));
		if (sum > CLAMP_HI) begin
			clamped = CLAMP_HI;
		end else if (sum < CLAMP_LO) begin
			clamped = CLAMP_LO;
		end else begin
			clamped = sum;
		end
		proj = clamped[COORD_BITS-1:0];
	end

	always_comb begin
		if (!started_q) begin
			nx_lo_col = col_q;
			nx_hi_col = col_q;
			nx_lo_row = row_q;
			nx_hi_row = row_q;
		end else begin
			nx_lo_col = (col_q < lo_col_q) ? col_q : lo_col_q;
			nx_hi_col = (col_q > hi_col_q) ? col_q : hi_col_q;
			nx_lo_row = (row_q < lo_row_q) ? row_q : lo_row_q;
			nx_hi_row = (row_q > hi_row_q) ? row_q : hi_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (cmd.update) begin
			started_q <= !last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= point_x;
			y_q    <= point_y;
			z_q    <= (point_z == '0) ? IN_W'(1) : point_z;
			last_q <= last_point;
		end
		if (cmd.mul) begin
			mag_c_q <= MAG_W'(abs_x) * MAG_W'(focal_length);
			mag_r_q <= MAG_W'(abs_y) * MAG_W'(focal_length);
			neg_c_q <= x_q[IN_W-1];
			neg_r_q <= y_q[IN_W-1];
		end
		if (cmd.fin_col) begin
			col_q <= proj;
		end
		if (cmd.fin_row) begin
			row_q <= proj;
		end
		if (cmd.update) begin
			lo_col_q <= nx_lo_col;
			hi_col_q <= nx_hi_col;
			lo_row_q <= nx_lo_row;
			hi_row_q <= nx_hi_row;
			if (last_q) begin
				min_column <= nx_lo_col;
				max_column <= nx_hi_col;
				min_row    <= nx_lo_row;
				max_row    <= nx_hi_row;
			end
		end
	end

	assign stat.div_done = div_done;
	assign stat.last     = last_q;

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (lo_col_q <= hi_col_q) && (lo_row_q <= hi_row_q))
		else $error("running box has minimum above maximum");

	a_box_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && last_q |=> !started_q)
		else $error("box not cleared after last point");

endmodule

>>> design/ppbb_ctrl.sv
// Controller: sequences capture, multiply, two divisions, finishing and
// the box update, and owns the stream handshakes. Depends on ppbb_pkg.
module ppbb_ctrl import ppbb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  ppbb_stat_t stat,
	output ppbb_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DSC  = 3'd2;
	localparam logic [2:0] S_DIVC = 3'd3;
	localparam logic [2:0] S_DSR  = 3'd4;
	localparam logic [2:0] S_DIVR = 3'd5;
	localparam logic [2:0] S_FINR = 3'd6;
	localparam logic [2:0] S_UPD  = 3'd7;

	logic [2:0] state_q, state_nx;
	logic       m_valid_q;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_DSC;
			end
			S_DSC: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIVC;
			end
			S_DIVC: begin
				if (stat.div_done) begin
					state_nx = S_DSR;
				end
			end
			S_DSR: begin
				// The column quotient is taken at the same edge the row division starts.
				cmd.fin_col   = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_row   = 1'b1;
				state_nx      = S_DIVR;
			end
			S_DIVR: begin
				cmd.div_row = 1'b1;
				if (stat.div_done) begin
					state_nx = S_FINR;
				end
			end
			S_FINR: begin
				cmd.fin_row = 1'b1;
				state_nx    = S_UPD;
			end
			S_UPD: begin
				if (!stat.last || out_free) begin
					cmd.update = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.update && stat.last) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == S_UPD)
		else $error("result word raised outside the update step");

endmodule

>>> design/projected_point_bounding_box.sv
// Top level of the projected point bounding box: configuration registers,
// controller and datapath. Depends on ppbb_pkg, ppbb_ctrl, ppbb_datapath.
//
// channel   direction  handshake                     content
// s_*       in         s_tvalid/s_tready             one 3D point, s_tlast ends the cluster
// m_*       out        m_tvalid/m_tready             image-plane box of the cluster
// APB       in/out     psel/penable, pready high     focal length and principal point
//
// After a word is accepted, s_tready stays low until that point has passed through
// the update step, so a new word is taken only once the previous point is done. The
// shared two-bit-per-cycle divider sets this time: it runs once for the column and
// once for the row. The box appears on m_tvalid the cycle after the last point
// finishes. A stalled result stalls only a later last point at its final step; other
// points keep flowing. Reset restores the default camera registers and empties the box.
module projected_point_bounding_box import ppbb_pkg::*; #(
	parameter  int COORD_BITS = 16,
	localparam int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,  // point_x, point_y, point_z
	input  logic               s_tlast,  // last_point
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata   // min_column, max_column, min_row, max_row
);

	logic [FOCAL_W-1:0] focal_q, ccol_q, crow_q;
	logic               wr_en;
	ppbb_cmd_t          cmd;
	ppbb_stat_t         stat;

	logic signed [COORD_BITS-1:0] min_column, max_column, min_row, max_row;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RST;
			ccol_q  <= CCOL_RST;
			crow_q  <= CROW_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FOCAL: focal_q <= pwdata[FOCAL_W-1:0];
				REG_CCOL:  ccol_q  <= pwdata[FOCAL_W-1:0];
				REG_CROW:  crow_q  <= pwdata[FOCAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FOCAL: prdata = PDATA_W'(focal_q);
			REG_CCOL:  prdata = PDATA_W'(ccol_q);
			REG_CROW:  prdata = PDATA_W'(crow_q);
			default:   prdata = '0;
		endcase
	end

	ppbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppbb_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.point_x       (s_tdata[15:0]),
		.point_y       (s_tdata[31:16]),
		.point_z       (s_tdata[47:32]),
		.last_point    (s_tlast),
		.focal_length  (focal_q),
		.center_column (ccol_q),
		.center_row    (crow_q),
		.min_column    (min_column),
		.max_column    (max_column),
		.min_row       (min_row),
		.max_row       (max_row)
	);

	assign m_tdata = TDATA_W'({max_row, min_row, max_column, min_column});

endmodule
